FILE: sv/bhss_pkg.sv
// Shared types and constants for the block header sequence segmenter.
// No dependencies; compiled first.

package bhss_pkg;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MAGIC      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_BLOCK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BLK  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ADC_PER_USER     = 2'd3;

	localparam int RATIO_W   = 11;
	localparam int PARTIAL_W = 10;
	localparam int SPB_W     = 16;
	localparam int BLOCKS_W  = 11;
	localparam logic [RATIO_W-1:0] RATIO_MAX = 11'd1024;

	localparam logic KIND_SEGMENT = 1'b0;
	localparam logic KIND_ERROR   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ADD,
		ST_MUL,
		ST_DIV_TS_START,
		ST_DIV_TS,
		ST_DIV_REM_START,
		ST_DIV_REM,
		ST_EMIT,
		ST_ERR
	} state_t;

	// Divider handshake seen by the sequencer.
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// A ratio of zero behaves as one, anything above 1024 as 1024.
	function automatic logic [RATIO_W-1:0] eff_ratio(input logic [RATIO_W-1:0] r);
		logic [RATIO_W-1:0] v;
		v = r;
		if (r == '0) begin
			v = RATIO_W'(1);
		end else if (r > RATIO_MAX) begin
			v = RATIO_MAX;
		end
		return v;
	endfunction

endpackage

FILE: sv/bhss_in_if.sv
// Input channel carrying one block header item.
// Standalone interface; no package dependency.

interface bhss_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] hdr_magic;
	logic [31:0] hdr_length;
	logic [31:0] hdr_samples;
	logic [31:0] hdr_sequence;
	logic        first_of_transfer;
	logic        last_of_transfer;

	modport source (
		output valid, hdr_magic, hdr_length, hdr_samples, hdr_sequence,
		       first_of_transfer, last_of_transfer,
		input  ready
	);
	modport sink (
		input  valid, hdr_magic, hdr_length, hdr_samples, hdr_sequence,
		       first_of_transfer, last_of_transfer,
		output ready
	);
endinterface

FILE: sv/bhss_out_if.sv
// Output channel carrying one segment report or error item.
// Standalone interface; no package dependency.

interface bhss_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] seg_timestamp;
	logic [10:0] seg_blocks;
	logic        last;

	modport source (
		output valid, kind, seg_timestamp, seg_blocks, last,
		input  ready
	);
	modport sink (
		input  valid, kind, seg_timestamp, seg_blocks, last,
		output ready
	);
endinterface

FILE: sv/block_header_sequence_segmenter_unit.sv
// Top level of the block header sequence segmenter: header check, run tracking and
// timestamp sequencer. Depends on bhss_pkg, bhss_in_if, bhss_out_if and bhss_div.
//
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   hdr_magic, hdr_length, hdr_samples, hdr_sequence,
//                               first_of_transfer, last_of_transfer
//  out_ch    out  valid/ready   kind, seg_timestamp, seg_blocks, last
//  cfg       in   cfg_we        cfg_index, cfg_wdata
//
// An item that closes no run goes through the check and add states only; each run
// it closes runs the one serial divider twice (DW = 32 at the default MAX_BLOCKS),
// once for the timestamp and once for the running remainder.
// in_ch is ready only in the idle state; out_ch has its own register, so a waiting
// result stalls the sequencer only when the next result must be written.
// Reset clears all run state and loads the register defaults.

module block_header_sequence_segmenter_unit
	import bhss_pkg::*;
#(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bhss_in_if.sink              in_ch,
	bhss_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_wdata
);

	localparam int CW   = $clog2(MAX_BLOCKS + 1);
	localparam int PW   = CW + SPB_W;
	localparam int DW   = (PW + 1 > 32) ? PW + 1 : 32;

	// Configuration registers.
	logic [31:0]        magic_q;
	logic [15:0]        bpb_q;
	logic [SPB_W-1:0]   spb_q;
	logic [RATIO_W-1:0] apu_q;

	// Captured input item.
	logic [31:0] magic_in_q;
	logic [31:0] length_in_q;
	logic [31:0] samples_in_q;
	logic [31:0] seq_in_q;
	logic        first_in_q;
	logic        last_in_q;

	// Run state.
	state_t               state_q, state_d;
	logic [31:0]          exp_seq_q;
	logic [31:0]          start_seq_q;
	logic [CW-1:0]        count_q;
	logic [PARTIAL_W-1:0] partial_q;
	logic                 halted_q;
	logic                 pre_close_q;

	// Closing arithmetic.
	logic [31:0] base_q;
	logic [PW-1:0] prod_q;
	logic [31:0] ts_q;

	// Output register.
	logic        out_valid_q;
	logic        out_kind_q;
	logic [31:0] out_ts_q;
	logic [BLOCKS_W-1:0] out_blocks_q;
	logic        out_last_q;

	// Divider connections.
	div_req_t           div_req;
	div_stat_t          div_stat;
	logic [DW-1:0]      div_dividend;
	logic [DW-1:0]      div_quotient;
	logic [RATIO_W-1:0] div_remainder;

	logic                 in_ready;
	logic                 slot_free;
	logic                 fmt_err;
	logic                 must_close;
	logic [SPB_W+31:0]    base_full;
	logic [CW+BLOCKS_W-1:0] count_ext;

	assign slot_free = !out_valid_q || out_ch.ready;
	assign fmt_err   = (magic_in_q != magic_q) || (length_in_q != {16'd0, bpb_q}) ||
	                   (samples_in_q != {16'd0, spb_q});
	assign must_close = (count_q != '0) && (first_in_q || (seq_in_q != exp_seq_q));
	assign base_full  = start_seq_q * spb_q;
	assign count_ext  = {{BLOCKS_W{1'b0}}, count_q};

	bhss_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (eff_ratio(apu_q)),
		.stat     (div_stat),
		.quotient (div_quotient),
		.remainder(div_remainder)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (halted_q) begin
					state_d = ST_IDLE;
				end else if (fmt_err) begin
					state_d = ST_ERR;
				end else if (must_close) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = last_in_q ? ST_MUL : ST_IDLE;
			end
			ST_MUL:           state_d = ST_DIV_TS_START;
			ST_DIV_TS_START:  state_d = ST_DIV_TS;
			ST_DIV_TS: begin
				if (div_stat.done) begin
					state_d = ST_DIV_REM_START;
				end
			end
			ST_DIV_REM_START: state_d = ST_DIV_REM;
			ST_DIV_REM: begin
				if (div_stat.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					state_d = pre_close_q ? ST_ADD : ST_IDLE;
				end
			end
			ST_ERR: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready      = 1'b0;
		div_req.start = 1'b0;
		div_dividend  = '0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_DIV_TS_START: begin
				div_req.start = 1'b1;
				div_dividend  = DW'(base_q - {22'd0, partial_q});
			end
			ST_DIV_REM_START: begin
				div_req.start = 1'b1;
				div_dividend  = DW'(prod_q) + DW'(partial_q);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign in_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
			bpb_q   <= 16'd1;
			spb_q   <= SPB_W'(1);
			apu_q   <= RATIO_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCK_MAGIC:     magic_q <= cfg_wdata;
				CFG_BYTES_PER_BLOCK: bpb_q   <= cfg_wdata[15:0];
				CFG_SAMPLES_PER_BLK: spb_q   <= cfg_wdata[SPB_W-1:0];
				CFG_ADC_PER_USER:    apu_q   <= cfg_wdata[RATIO_W-1:0];
				default:             magic_q <= magic_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_ch.valid) begin
			magic_in_q   <= in_ch.hdr_magic;
			length_in_q  <= in_ch.hdr_length;
			samples_in_q <= in_ch.hdr_samples;
			seq_in_q     <= in_ch.hdr_sequence;
			first_in_q   <= in_ch.first_of_transfer;
			last_in_q    <= in_ch.last_of_transfer;
		end
		if (state_q == ST_MUL) begin
			base_q <= base_full[31:0];
			prod_q <= count_q * spb_q;
		end
		if (state_q == ST_DIV_TS && div_stat.done) begin
			ts_q <= div_quotient[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			exp_seq_q   <= '0;
			start_seq_q <= '0;
			count_q     <= '0;
			partial_q   <= '0;
			halted_q    <= 1'b0;
			pre_close_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_EMIT || state_q == ST_ERR) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CHECK: begin
					pre_close_q <= must_close;
					if (!halted_q && fmt_err) begin
						count_q  <= '0;
						halted_q <= 1'b1;
					end
				end
				ST_ADD: begin
					pre_close_q <= 1'b0;
					if (count_q == '0) begin
						start_seq_q <= seq_in_q;
						count_q     <= CW'(1);
					end else if (count_q < CW'(MAX_BLOCKS)) begin
						count_q <= count_q + CW'(1);
					end
					exp_seq_q <= seq_in_q + 32'd1;
				end
				ST_DIV_REM: begin
					if (div_stat.done) begin
						partial_q <= div_remainder[PARTIAL_W-1:0];
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						count_q <= '0;
					end
				end
				default: begin
					halted_q <= halted_q;
				end
			endcase
		end
	end

	// A close before the new block is added is final only if no trailing close follows.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) begin
			out_kind_q   <= KIND_SEGMENT;
			out_ts_q     <= ts_q;
			out_blocks_q <= count_ext[BLOCKS_W-1:0];
			out_last_q   <= pre_close_q ? !last_in_q : 1'b1;
		end else if (state_q == ST_ERR && slot_free) begin
			out_kind_q   <= KIND_ERROR;
			out_ts_q     <= '0;
			out_blocks_q <= '0;
			out_last_q   <= 1'b1;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.kind          = out_kind_q;
	assign out_ch.seg_timestamp = out_ts_q;
	assign out_ch.seg_blocks    = out_blocks_q;
	assign out_ch.last          = out_last_q;

endmodule

FILE: sv/bhss_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on bhss_pkg for the request and status structs.

module bhss_div
	import bhss_pkg::*;
#(
	parameter int DW = 34
) (
	input  logic               clk,
	input  logic               arst_n,
	input  div_req_t           req,
	input  logic [DW-1:0]      dividend,
	input  logic [RATIO_W-1:0] divisor,
	output div_stat_t          stat,
	output logic [DW-1:0]      quotient,
	output logic [RATIO_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DW + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DW-1:0]      quo_q;
	logic [RATIO_W-1:0] rem_q;
	logic [RATIO_W-1:0] dvs_q;

	logic [RATIO_W:0]   trial;
	logic               fits;
	logic [RATIO_W:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		fits  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The remainder stays below the divisor, so it fits in RATIO_W bits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? diff[RATIO_W-1:0] : trial[RATIO_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: dv/tb_top.sv
// Testbench for block_header_sequence_segmenter_unit: drives block headers, predicts the
// segment reports and format errors they cause, and checks every result field by field.
// Depends on bhss_pkg, bhss_in_if, bhss_out_if and the unit itself.

module tb_top;
	import bhss_pkg::*;

	localparam int SEG_MAX_BLOCKS = 1024;

	typedef struct packed {
		logic [31:0] magic;
		logic [31:0] length;
		logic [31:0] samples;
		logic [31:0] seq_num;
		logic        first_blk;
		logic        last_blk;
	} blk_hdr_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] ts;
		logic [10:0] blocks;
		logic        last_rpt;
	} seg_rpt_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;

	bhss_in_if  in_ch ();
	bhss_out_if out_ch ();

	block_header_sequence_segmenter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Copy of the register file as the unit should hold it.
	logic [31:0] cfg_magic = 32'd0;
	logic [15:0] cfg_bpb   = 16'd1;
	logic [15:0] cfg_spb   = 16'd1;
	logic [10:0] cfg_ratio = 11'd1;

	// Run tracking state of the unit.
	logic [31:0] next_seq     = 32'd0;
	logic [31:0] run_start    = 32'd0;
	logic [10:0] run_blocks   = 11'd0;
	logic [31:0] carry_rem    = 32'd0;
	logic        stopped      = 1'b0;

	seg_rpt_t pending_reports[$];
	seg_rpt_t want;
	int       mismatches = 0;
	int       snd_idle_pct = 35;
	int       rcv_idle_pct = 48;

	always #2 clk = ~clk;

	// Timestamps divide by the ratio clamped into 1..1024.
	function automatic logic [31:0] clamped_ratio();
		if (cfg_ratio == 11'd0) begin
			return 32'd1;
		end
		if (cfg_ratio > 11'd1024) begin
			return 32'd1024;
		end
		return {21'd0, cfg_ratio};
	endfunction

	function automatic seg_rpt_t close_segment();
		logic [31:0] div;
		logic [31:0] base;
		logic [31:0] sum;
		seg_rpt_t    r;
		div  = clamped_ratio();
		base = run_start * {16'd0, cfg_spb};
		sum  = carry_rem + {21'd0, run_blocks} * {16'd0, cfg_spb};
		r.kind     = KIND_SEGMENT;
		r.ts       = (base - carry_rem) / div;
		r.blocks   = run_blocks;
		r.last_rpt = 1'b0;
		carry_rem  = sum % div;
		run_blocks = 11'd0;
		return r;
	endfunction

	function automatic void predict_header(input blk_hdr_t h);
		seg_rpt_t r[2];
		int       n;
		n = 0;
		if (stopped) begin
			return;
		end
		if (h.magic != cfg_magic || h.length != {16'd0, cfg_bpb} ||
		    h.samples != {16'd0, cfg_spb}) begin
			run_blocks = 11'd0;
			stopped    = 1'b1;
			pending_reports.push_back('{KIND_ERROR, 32'd0, 11'd0, 1'b1});
			return;
		end
		if (run_blocks != 11'd0 && (h.first_blk || h.seq_num != next_seq)) begin
			r[n] = close_segment();
			n = n + 1;
		end
		if (run_blocks == 11'd0) begin
			run_start  = h.seq_num;
			run_blocks = 11'd1;
		end else if (run_blocks < SEG_MAX_BLOCKS) begin
			run_blocks = run_blocks + 11'd1;
		end
		next_seq = h.seq_num + 32'd1;
		if (h.last_blk) begin
			r[n] = close_segment();
			n = n + 1;
		end
		if (n > 0) begin
			r[n-1].last_rpt = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			pending_reports.push_back(r[i]);
		end
	endfunction

	function automatic blk_hdr_t good_header(input logic [31:0] s, input logic f,
	                                         input logic l);
		blk_hdr_t h;
		h = '{cfg_magic, {16'd0, cfg_bpb}, {16'd0, cfg_spb}, s, f, l};
		return h;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance with
	// valid still high, so back-to-back items keep it up.
	task automatic send_header(input blk_hdr_t h);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid             <= 1'b1;
		in_ch.hdr_magic         <= h.magic;
		in_ch.hdr_length        <= h.length;
		in_ch.hdr_samples       <= h.samples;
		in_ch.hdr_sequence      <= h.seq_num;
		in_ch.first_of_transfer <= h.first_blk;
		in_ch.last_of_transfer  <= h.last_blk;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		predict_header(h);
		@(negedge clk);
	endtask

	// Stops sending and waits until every expected report is in, then lets an item
	// that closes no run finish as well.
	task automatic wait_for_reports();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_reports.size() != 0) begin
			@(negedge clk);
		end
		repeat (200) @(negedge clk);
	endtask

	task automatic write_regs(input logic [31:0] magic_w, input logic [31:0] bpb_w,
	                          input logic [31:0] spb_w, input logic [31:0] ratio_w);
		logic [31:0] words[4];
		logic [1:0]  idx[4];
		words = '{magic_w, bpb_w, spb_w, ratio_w};
		idx   = '{CFG_BLOCK_MAGIC, CFG_BYTES_PER_BLOCK, CFG_SAMPLES_PER_BLK,
		          CFG_ADC_PER_USER};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= words[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
		cfg_magic = magic_w;
		cfg_bpb   = bpb_w[15:0];
		cfg_spb   = spb_w[15:0];
		cfg_ratio = ratio_w[10:0];
	endtask

	task automatic write_random_regs();
		logic [31:0] magic;
		logic [15:0] bpb;
		logic [15:0] spb;
		logic [10:0] ratio;
		logic [31:0] junk;
		logic        dirty;
		junk  = $urandom;
		dirty = 1'($urandom_range(1));
		case ($urandom_range(3))
			0: magic = 32'd0;
			1: magic = 32'hFFFF_FFFF;
			default: magic = $urandom;
		endcase
		case ($urandom_range(3))
			0: bpb = 16'd1;
			1: bpb = 16'hFFFF;
			default: bpb = 16'($urandom_range(1, 65535));
		endcase
		case ($urandom_range(3))
			0: spb = 16'($urandom_range(1, 16));
			1: spb = $urandom_range(1) ? 16'd1 : 16'hFFFF;
			default: spb = 16'($urandom_range(1, 65535));
		endcase
		case ($urandom_range(9))
			0: ratio = 11'd1;
			1: ratio = 11'd1024;
			2: ratio = 11'd0;
			3: ratio = 11'($urandom_range(1025, 2047));
			default: ratio = 11'($urandom_range(2, 1024));
		endcase
		write_regs(magic,
		           {dirty ? junk[31:16] : 16'd0, bpb},
		           {dirty ? junk[15:0] : 16'd0, spb},
		           {dirty ? junk[20:0] : 21'd0, ratio});
	endtask

	// Register defaults after reset: magic 0, length 1, one sample, ratio 1.
	task automatic test_reset_defaults();
		send_header('{32'd0, 32'd1, 32'd1, 32'd5, 1'b1, 1'b0});
		send_header('{32'd0, 32'd1, 32'd1, 32'd6, 1'b0, 1'b0});
		send_header('{32'd0, 32'd1, 32'd1, 32'd7, 1'b0, 1'b1});
		wait_for_reports();
	endtask

	task automatic test_run_boundaries();
		write_regs(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'd1024);
		// A run that crosses the sequence wrap.
		send_header(good_header(32'hFFFF_FFFE, 1'b1, 1'b0));
		send_header(good_header(32'hFFFF_FFFF, 1'b0, 1'b0));
		send_header(good_header(32'd0, 1'b0, 1'b1));
		// No first flag after a closed run, then a sequence gap.
		send_header(good_header(32'd10, 1'b0, 1'b0));
		send_header(good_header(32'd12, 1'b0, 1'b0));
		send_header(good_header(32'd13, 1'b0, 1'b0));
		// First and last on one block while a run is open gives two reports.
		send_header(good_header(32'd100, 1'b1, 1'b1));
		// A transfer that never sees its last block.
		send_header(good_header(32'd200, 1'b1, 1'b0));
		send_header(good_header(32'd201, 1'b0, 1'b0));
		send_header(good_header(32'd300, 1'b1, 1'b0));
		send_header(good_header(32'd301, 1'b0, 1'b1));
		wait_for_reports();
		// Length, samples and ratio writes carry junk above the register width; ratio 0 acts as 1.
		write_regs(32'd0, 32'hABCD_0001, 32'hFFFF_0000, 32'hFFFF_F800);
		send_header(good_header(32'd7, 1'b1, 1'b0));
		send_header(good_header(32'd8, 1'b0, 1'b1));
		send_header(good_header(32'd5, 1'b1, 1'b1));
		wait_for_reports();
		// A ratio above 1024 acts as 1024.
		write_regs($urandom, 32'd1, 32'd1, 32'd2047);
		send_header(good_header(32'd1000, 1'b1, 1'b0));
		send_header(good_header(32'd1001, 1'b0, 1'b0));
		send_header(good_header(32'd1003, 1'b0, 1'b1));
		send_header(good_header(32'd0, 1'b1, 1'b1));
		wait_for_reports();
	endtask

	// More blocks than MAX_BLOCKS: the count stays at its ceiling.
	task automatic test_long_run();
		write_regs(32'h5A5A_A5A5, 32'd512, 32'd4096, 32'd3);
		for (int i = 0; i < SEG_MAX_BLOCKS + 6; i++) begin
			send_header(good_header(32'hFFFF_FE00 + i, i == 0,
			                        i == SEG_MAX_BLOCKS + 5));
		end
		wait_for_reports();
	endtask

	task automatic run_random_items(input int count);
		logic [31:0] seq;
		logic [31:0] nxt;
		logic        open_xfer;
		logic        f;
		logic        l;
		int          pick;
		nxt       = $urandom;
		open_xfer = 1'b0;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (!open_xfer || pick < 8) begin
				seq = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(20)
				                               : $urandom;
				f = open_xfer ? 1'b1 : ($urandom_range(9) != 0);
				open_xfer = 1'b1;
			end else if (pick < 16) begin
				seq = nxt + $urandom_range(1, 1000);
				f = 1'b0;
			end else if (pick < 20) begin
				seq = $urandom;
				f = 1'($urandom_range(1));
			end else begin
				seq = nxt;
				f = 1'b0;
			end
			l = ($urandom_range(99) < 12);
			if (l) begin
				open_xfer = 1'b0;
			end
			nxt = seq + 32'd1;
			send_header(good_header(seq, f, l));
		end
	endtask

	task automatic test_random_transfers();
		int snd_pcts[3];
		int rcv_pcts[3];
		snd_pcts = '{35, 48, 0};
		rcv_pcts = '{48, 35, 0};
		for (int p = 0; p < 3; p++) begin
			snd_idle_pct = snd_pcts[p];
			rcv_idle_pct = rcv_pcts[p];
			for (int k = 0; k < 3; k++) begin
				write_random_regs();
				run_random_items(8);
				wait_for_reports();
			end
		end
	endtask

	// A bad header drops the open run, reports once and the unit then ignores input.
	task automatic test_format_error();
		write_random_regs();
		send_header(good_header(32'd50, 1'b1, 1'b0));
		send_header(good_header(32'd51, 1'b0, 1'b0));
		send_header('{~cfg_magic, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd52, 1'b0, 1'b0});
		send_header(good_header(32'd52, 1'b0, 1'b1));
		send_header(good_header(32'd60, 1'b1, 1'b1));
		wait_for_reports();
	endtask

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected result: kind %0b, seg_timestamp %0h, seg_blocks %0d",
				       out_ch.kind, out_ch.seg_timestamp, out_ch.seg_blocks);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				if (out_ch.kind !== want.kind) begin
					$error("kind: expected %0b, actual %0b", want.kind, out_ch.kind);
					mismatches++;
				end
				if (out_ch.seg_timestamp !== want.ts) begin
					$error("seg_timestamp: expected %0h, actual %0h", want.ts,
					       out_ch.seg_timestamp);
					mismatches++;
				end
				if (out_ch.seg_blocks !== want.blocks) begin
					$error("seg_blocks: expected %0d, actual %0d", want.blocks,
					       out_ch.seg_blocks);
					mismatches++;
				end
				if (out_ch.last !== want.last_rpt) begin
					$error("last: expected %0b, actual %0b", want.last_rpt, out_ch.last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		clk                     = 1'b0;
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = CFG_BLOCK_MAGIC;
		cfg_wdata               = 32'd0;
		in_ch.valid             = 1'b0;
		in_ch.hdr_magic         = 32'd0;
		in_ch.hdr_length        = 32'd0;
		in_ch.hdr_samples       = 32'd0;
		in_ch.hdr_sequence      = 32'd0;
		in_ch.first_of_transfer = 1'b0;
		in_ch.last_of_transfer  = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_run_boundaries();
		test_long_run();
		test_random_transfers();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_format_error();

		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/bhss_pkg.sv
sv/bhss_in_if.sv
sv/bhss_out_if.sv
sv/bhss_div.sv
sv/block_header_sequence_segmenter_unit.sv
dv/tb_top.sv
